// File: rtl/ccd_pkg.sv
package ccd_pkg;

  localparam int IDX_W  = 8;
  localparam int IN_W   = 16;
  localparam int CORR_W = 25;
  localparam int MAG_W  = 48;
  localparam int HALF_W = MAG_W / 2;

  localparam logic [MAG_W-1:0] THRESH_RESET = 48'h0000_0006_9000;

  localparam logic [2:0] MAG_STEPS = 3'd4;

  typedef enum logic {
    OP_COEFF,
    OP_SAMPLE
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ABS,
    ST_MAG,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic q_ready;
    logic clear_busy;
  } back_status_t;

endpackage

// File: rtl/ccd_if.sv
interface ccd_item_if import ccd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [IDX_W-1:0]        coeff_index;
  logic signed [IN_W-1:0]  in_real;
  logic signed [IN_W-1:0]  in_imag;

  modport source (output valid, func, coeff_index, in_real, in_imag, input ready);
  modport sink   (input valid, func, coeff_index, in_real, in_imag, output ready);
endinterface

interface ccd_result_if import ccd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CORR_W-1:0] corr_real;
  logic signed [CORR_W-1:0] corr_imag;
  logic [MAG_W-1:0]         magnitude_sq;
  logic                     detected;

  modport source (output valid, corr_real, corr_imag, magnitude_sq, detected, input ready);
  modport sink   (input valid, corr_real, corr_imag, magnitude_sq, detected, output ready);
endinterface

interface ccd_cfg_if import ccd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/ccd_ram.sv
module ccd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ccd_front.sv
module ccd_front import ccd_pkg::*; #(
  parameter int TAPS      = 256,
  parameter int PART_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  ccd_item_if.sink              items,
  input  back_status_t          status,
  output logic                  q_valid,
  output op_t                   q_op,
  output logic [IDX_W-1:0]      q_index,
  output logic [PART_BITS-1:0]  q_re,
  output logic [PART_BITS-1:0]  q_im
);

  localparam int EXT_W = IN_W + PART_BITS;

  op_t                  e_op  [2];
  logic [IDX_W-1:0]     e_idx [2];
  logic [PART_BITS-1:0] e_re  [2];
  logic [PART_BITS-1:0] e_im  [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;

  logic [EXT_W-1:0]     ext_re;
  logic [EXT_W-1:0]     ext_im;
  logic                 keep;
  logic                 accept;
  logic                 push;
  logic                 pop;

  assign ext_re = {{PART_BITS{1'b0}}, items.in_real};
  assign ext_im = {{PART_BITS{1'b0}}, items.in_imag};

  // drop coefficient writes past the last tap
  assign keep   = items.func || (32'(items.coeff_index) < TAPS);

  assign items.ready = !status.clear_busy && (count != 2'd2);
  assign accept      = items.valid && items.ready;
  assign push        = accept && keep;
  assign pop         = q_valid && status.q_ready;

  assign q_valid = (count != 2'd0);
  assign q_op    = e_op[rd_ptr];
  assign q_index = e_idx[rd_ptr];
  assign q_re    = e_re[rd_ptr];
  assign q_im    = e_im[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      e_op[wr_ptr]  <= items.func ? OP_SAMPLE : OP_COEFF;
      e_idx[wr_ptr] <= items.coeff_index;
      e_re[wr_ptr]  <= ext_re[PART_BITS-1:0];
      e_im[wr_ptr]  <= ext_im[PART_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ccd_back.sv
module ccd_back import ccd_pkg::*; #(
  parameter int TAPS      = 256,
  parameter int PART_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  op_t                  q_op,
  input  logic [IDX_W-1:0]     q_index,
  input  logic [PART_BITS-1:0] q_re,
  input  logic [PART_BITS-1:0] q_im,
  output back_status_t         status,
  ccd_cfg_if.sink              cfg,
  ccd_result_if.source         results
);

  localparam int LW = $clog2(TAPS);
  localparam int DW = 2 * PART_BITS;
  localparam int PW = 2 * PART_BITS;
  localparam int AW = PART_BITS + LW + 2;
  localparam logic [LW-1:0] LAST = LW'(TAPS - 1);

  state_t state;
  state_t state_next;

  logic [MAG_W-1:0] threshold;

  logic [LW-1:0] head;
  logic [LW-1:0] pos;
  logic [LW-1:0] tcnt;
  logic [LW-1:0] clr_cnt;

  logic          line_we;
  logic [LW-1:0] line_waddr;
  logic [DW-1:0] line_wdata;
  logic [DW-1:0] line_rdata;
  logic          coeff_we;
  logic [DW-1:0] coeff_rdata;
  logic [LW-1:0] head_dec;
  logic          start_sample;
  logic          issue;

  logic rd_v;
  logic prod_v;

  logic signed [PART_BITS-1:0] sr;
  logic signed [PART_BITS-1:0] si;
  logic signed [PART_BITS-1:0] cr;
  logic signed [PART_BITS-1:0] ci;
  logic signed [PW-1:0] prr;
  logic signed [PW-1:0] pii;
  logic signed [PW-1:0] pri;
  logic signed [PW-1:0] pir;
  logic signed [PART_BITS-1:0] trr;
  logic signed [PART_BITS-1:0] tii;
  logic signed [PART_BITS-1:0] tri_s;
  logic signed [PART_BITS-1:0] tir;
  logic signed [AW-1:0] acc_re;
  logic signed [AW-1:0] acc_im;

  logic [AW-1:0]     abs_re;
  logic [AW-1:0]     abs_im;
  logic [MAG_W-1:0]  wide_re;
  logic [MAG_W-1:0]  wide_im;
  logic [2:0]        mcnt;
  logic [HALF_W-1:0] ma;
  logic [HALF_W-1:0] mb;
  logic [MAG_W-1:0]  preg;
  logic [1:0]        ptag;
  logic              pv;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  term;
  logic              load_out;

  assign head_dec = (head == '0) ? LAST : head - LW'(1);

  ccd_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (pos),
    .rdata (line_rdata)
  );

  ccd_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_coeff (
    .clk   (clk),
    .we    (coeff_we),
    .waddr (LW'(q_index)),
    .wdata ({q_re, q_im}),
    .raddr (tcnt),
    .rdata (coeff_rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.data;
    end
  end

  always_comb begin
    state_next        = state;
    status.q_ready    = 1'b0;
    status.clear_busy = (state == ST_CLEAR);
    line_we           = 1'b0;
    line_waddr        = clr_cnt;
    line_wdata        = '0;
    coeff_we          = 1'b0;
    start_sample      = 1'b0;
    issue             = 1'b0;
    load_out          = 1'b0;
    case (state)
      ST_CLEAR: begin
        line_we = 1'b1;
        if (clr_cnt == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          status.q_ready = 1'b1;
          if (q_op == OP_SAMPLE) begin
            start_sample = 1'b1;
            line_we      = 1'b1;
            line_waddr   = head_dec;
            line_wdata   = {q_re, q_im};
            state_next   = ST_MAC;
          end else begin
            coeff_we = 1'b1;
          end
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (tcnt == LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v && !prod_v) begin
          state_next = ST_ABS;
        end
      end
      ST_ABS: begin
        state_next = ST_MAG;
      end
      ST_MAG: begin
        if (mcnt == MAG_STEPS) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!results.valid || results.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      head    <= '0;
      rd_v    <= 1'b0;
      prod_v  <= 1'b0;
      pv      <= 1'b0;
    end else begin
      state  <= state_next;
      rd_v   <= issue;
      prod_v <= rd_v;
      pv     <= (state == ST_MAG) && (mcnt != MAG_STEPS);
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + LW'(1);
      end
      if (start_sample) begin
        head <= head_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_sample) begin
      pos  <= head_dec;
      tcnt <= '0;
    end else if (issue) begin
      pos  <= (pos == LAST) ? '0 : pos + LW'(1);
      tcnt <= tcnt + LW'(1);
    end
  end

  assign sr = line_rdata[DW-1:PART_BITS];
  assign si = line_rdata[PART_BITS-1:0];
  assign cr = coeff_rdata[DW-1:PART_BITS];
  assign ci = coeff_rdata[PART_BITS-1:0];

  always_ff @(posedge clk) begin
    prr <= sr * cr;
    pii <= si * ci;
    pri <= sr * ci;
    pir <= si * cr;
  end

  assign trr   = prr[PW-1:PART_BITS];
  assign tii   = pii[PW-1:PART_BITS];
  assign tri_s = pri[PW-1:PART_BITS];
  assign tir   = pir[PW-1:PART_BITS];

  always_ff @(posedge clk) begin
    if (start_sample) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (prod_v) begin
      acc_re <= acc_re + AW'(trr) - AW'(tii);
      acc_im <= acc_im + AW'(tri_s) + AW'(tir);
    end
  end

  assign wide_re = {{(MAG_W-AW){1'b0}}, abs_re};
  assign wide_im = {{(MAG_W-AW){1'b0}}, abs_im};

  always_comb begin
    case (mcnt)
      3'd0: begin
        ma = wide_re[HALF_W-1:0];
        mb = wide_re[HALF_W-1:0];
      end
      3'd1: begin
        ma = wide_re[MAG_W-1:HALF_W];
        mb = wide_re[HALF_W-1:0];
      end
      3'd2: begin
        ma = wide_im[HALF_W-1:0];
        mb = wide_im[HALF_W-1:0];
      end
      3'd3: begin
        ma = wide_im[MAG_W-1:HALF_W];
        mb = wide_im[HALF_W-1:0];
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // cross terms: 2*hi*lo lands at the upper half, wrapped to the word
  assign term = ptag[0] ? {preg[HALF_W-2:0], {(HALF_W+1){1'b0}}} : preg;

  always_ff @(posedge clk) begin
    if (state == ST_ABS) begin
      abs_re <= acc_re[AW-1] ? -acc_re : acc_re;
      abs_im <= acc_im[AW-1] ? -acc_im : acc_im;
      mag    <= '0;
      mcnt   <= '0;
    end else begin
      if (state == ST_MAG) begin
        mcnt <= mcnt + 3'd1;
        preg <= ma * mb;
        ptag <= mcnt[1:0];
      end
      if (pv) begin
        mag <= mag + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load_out) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.corr_real    <= CORR_W'(acc_re);
      results.corr_imag    <= CORR_W'(acc_im);
      results.magnitude_sq <= mag;
      results.detected     <= (mag >= threshold);
    end
  end

endmodule

// File: rtl/complex_correlator_detector_top.sv
// channel   dir  transaction moves
// items     in   func, coeff_index, in_real, in_imag
// results   out  corr_real, corr_imag, magnitude_sq, detected
// cfg       in   detect_threshold write data
//
// In the back end a sample runs one complex tap MAC per cycle, bound by the
// single read port of the sample line, then a 4-step magnitude square on one
// 24x24 multiplier. After reset a clearing pass zeroes the sample line;
// items wait. A two-entry queue and the output register let each side stall
// on its own.
module complex_correlator_detector_top import ccd_pkg::*; #(
  parameter int TAPS      = 256,
  parameter int PART_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  ccd_item_if.sink      items,
  ccd_cfg_if.sink       cfg,
  ccd_result_if.source  results
);

  back_status_t         status;
  logic                 q_valid;
  op_t                  q_op;
  logic [IDX_W-1:0]     q_index;
  logic [PART_BITS-1:0] q_re;
  logic [PART_BITS-1:0] q_im;

  ccd_front #(.TAPS(TAPS), .PART_BITS(PART_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .status  (status),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_index (q_index),
    .q_re    (q_re),
    .q_im    (q_im)
  );

  ccd_back #(.TAPS(TAPS), .PART_BITS(PART_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_index (q_index),
    .q_re    (q_re),
    .q_im    (q_im),
    .status  (status),
    .cfg     (cfg),
    .results (results)
  );

endmodule
